FILE: hdl/sqmr_pkg.sv
`default_nettype none
package sqmr_pkg;

  localparam logic [3:0] MAX_SIDE = 4'd8;
  localparam int DEPTH = 64;
  localparam int AW = 6;
  localparam int DW = 32;
  localparam int CW = 3;

  typedef enum logic [2:0] {
    KIND_BEGIN = 3'd0,
    KIND_ELEM  = 3'd1,
    KIND_CW    = 3'd2,
    KIND_CCW   = 3'd3,
    KIND_PRINT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ELEM        = 2'd0,
    STAT_PRINT_EMPTY = 2'd1,
    STAT_ROT_EMPTY   = 2'd2
  } status_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_PRINT
  } seq_state_e;

  // logical position of a printed element plus the matrix view
  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic [3:0]    side;
    logic [1:0]    orient;
  } pos_t;

  // result under way while the store read is in flight
  typedef struct packed {
    status_e status;
    logic    zero;
    logic    row_end;
    logic    last;
  } meta_t;

  typedef struct packed {
    status_e       status;
    logic [DW-1:0] value;
    logic          row_end;
    logic          last;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/sqmr_mem.sv
`default_nettype none
module sqmr_mem (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [sqmr_pkg::AW-1:0] waddr_i,
  input  wire logic [sqmr_pkg::DW-1:0] wdata_i,
  input  wire logic                   re_i,
  input  wire logic [sqmr_pkg::AW-1:0] raddr_i,
  output logic      [sqmr_pkg::DW-1:0] rdata_o
);

  logic [sqmr_pkg::DW-1:0] mem [sqmr_pkg::DEPTH];
  logic [sqmr_pkg::DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/sqmr_addr.sv
`default_nettype none
module sqmr_addr (
  input  wire sqmr_pkg::pos_t         pos_i,
  output logic [sqmr_pkg::AW-1:0]     index_o
);

  logic [3:0]              side_m1;
  logic [sqmr_pkg::CW-1:0] nm1;
  logic [sqmr_pkg::CW-1:0] pr;
  logic [sqmr_pkg::CW-1:0] pc;
  logic [6:0]              lin;

  // turn the logical (row, col) back to the row-major load position
  always_comb begin
    side_m1 = pos_i.side - 4'd1;
    nm1     = side_m1[sqmr_pkg::CW-1:0];
    case (pos_i.orient)
      2'd0: begin
        pr = pos_i.row;
        pc = pos_i.col;
      end
      2'd1: begin
        pr = nm1 - pos_i.col;
        pc = pos_i.row;
      end
      2'd2: begin
        pr = nm1 - pos_i.row;
        pc = nm1 - pos_i.col;
      end
      default: begin
        pr = pos_i.col;
        pc = nm1 - pos_i.row;
      end
    endcase
    lin     = {4'b0, pr} * {3'b0, pos_i.side} + {4'b0, pc};
    index_o = lin[sqmr_pkg::AW-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/square_matrix_rotator.sv
`default_nettype none
// Square matrix store with quarter-turn view, up to 8 x 8 signed 32-bit words.
// Input stream: tuser carries the command kind (begin, element, rotate
// clockwise, rotate counter-clockwise, print); tdata carries side and value.
// Begin, element and rotate transactions are taken one per cycle while the
// output queue has room and give no result, except a rotate on an empty
// matrix, which gives one status result. Rotation only changes an
// orientation register; words never move. A print streams the n*n elements
// row by row, one per cycle while the receiver keeps up, from the single read
// port of the element memory; tdata bit 32 marks row ends and tlast the final
// element. The input is held off for the whole print. An element result is
// registered in the memory read port, a status result in the meta register.
// Results go through a two-entry output queue; memory reads are issued only
// when queue space is certain, so a stalled receiver simply holds the stream
// and no result is lost. Reset empties the matrix (side 0), clears the
// orientation and load count and drops queued results; memory contents are
// not cleared, unloaded positions print as zero.
module square_matrix_rotator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // side[3:0], value[35:4], zero fill
  input  wire logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // value_res[31:0], row_end[32], zero fill
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  output logic             m_axis_tlast
);

  logic [3:0]                 side_q, side_d;
  logic [1:0]                 orient_q, orient_d;
  logic [6:0]                 load_q, load_d;
  sqmr_pkg::seq_state_e       state_q, state_d;
  logic [sqmr_pkg::CW-1:0]    row_q, row_d, col_q, col_d;
  logic                       flight_q, flight_d;
  sqmr_pkg::meta_t            meta_q, meta_d;
  sqmr_pkg::result_t          fifo_q [2];
  logic                       wptr_q, rptr_q;
  logic [1:0]                 cnt_q;

  logic                       in_acc, pop, push, can_issue, we;
  logic [2:0]                 room;
  logic [3:0]                 in_side;
  logic [sqmr_pkg::DW-1:0]    in_value;
  logic [6:0]                 area;
  logic [3:0]                 side_m1;
  logic [sqmr_pkg::CW-1:0]    nm1;
  sqmr_pkg::pos_t             pos;
  logic [sqmr_pkg::AW-1:0]    rd_index;
  logic [sqmr_pkg::DW-1:0]    rdata;
  sqmr_pkg::result_t          push_res, head;
  logic                       re;

  assign in_side  = s_axis_tdata[3:0];
  assign in_value = s_axis_tdata[35:4];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign pop      = (cnt_q != 2'd0) && m_axis_tready;
  assign push     = flight_q;
  assign room     = {1'b0, cnt_q} + {2'b0, flight_q} - {2'b0, pop};
  assign can_issue = room < 3'd2;
  assign s_axis_tready = (state_q == sqmr_pkg::SEQ_IDLE) && can_issue;

  assign area    = {3'b0, side_q} * {3'b0, side_q};
  assign side_m1 = side_q - 4'd1;
  assign nm1     = side_m1[sqmr_pkg::CW-1:0];
  assign pos     = '{row: row_q, col: col_q, side: side_q, orient: orient_q};

  sqmr_addr u_addr (
    .pos_i   (pos),
    .index_o (rd_index)
  );

  sqmr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (load_q[sqmr_pkg::AW-1:0]),
    .wdata_i (in_value),
    .re_i    (re),
    .raddr_i (rd_index),
    .rdata_o (rdata)
  );

  always_comb begin
    side_d   = side_q;
    orient_d = orient_q;
    load_d   = load_q;
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    flight_d = 1'b0;
    meta_d   = meta_q;
    we       = 1'b0;
    re       = 1'b0;
    case (state_q)
      sqmr_pkg::SEQ_IDLE: begin
        if (in_acc) begin
          case (sqmr_pkg::kind_e'(s_axis_tuser))
            sqmr_pkg::KIND_BEGIN: begin
              side_d   = (in_side > sqmr_pkg::MAX_SIDE) ? sqmr_pkg::MAX_SIDE : in_side;
              orient_d = 2'd0;
              load_d   = 7'd0;
            end
            sqmr_pkg::KIND_ELEM: begin
              if (load_q < area) begin
                we     = 1'b1;
                load_d = load_q + 7'd1;
              end
            end
            sqmr_pkg::KIND_CW, sqmr_pkg::KIND_CCW: begin
              if (side_q == 4'd0) begin
                flight_d = 1'b1;
                meta_d   = '{status: sqmr_pkg::STAT_ROT_EMPTY, zero: 1'b1,
                             row_end: 1'b0, last: 1'b1};
              end else if (sqmr_pkg::kind_e'(s_axis_tuser) == sqmr_pkg::KIND_CW) begin
                orient_d = orient_q + 2'd1;
              end else begin
                orient_d = orient_q - 2'd1;
              end
            end
            sqmr_pkg::KIND_PRINT: begin
              if (side_q == 4'd0) begin
                flight_d = 1'b1;
                meta_d   = '{status: sqmr_pkg::STAT_PRINT_EMPTY, zero: 1'b1,
                             row_end: 1'b0, last: 1'b1};
              end else begin
                state_d = sqmr_pkg::SEQ_PRINT;
                row_d   = '0;
                col_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      sqmr_pkg::SEQ_PRINT: begin
        if (can_issue) begin
          re       = 1'b1;
          flight_d = 1'b1;
          meta_d.status  = sqmr_pkg::STAT_ELEM;
          // positions beyond the load count were never written
          meta_d.zero    = !({1'b0, rd_index} < load_q);
          meta_d.row_end = (col_q == nm1);
          meta_d.last    = (col_q == nm1) && (row_q == nm1);
          if (col_q == nm1) begin
            col_d = '0;
            if (row_q == nm1) begin
              state_d = sqmr_pkg::SEQ_IDLE;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = sqmr_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= 4'd0;
      orient_q <= 2'd0;
      load_q   <= 7'd0;
      state_q  <= sqmr_pkg::SEQ_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      flight_q <= 1'b0;
    end else begin
      side_q   <= side_d;
      orient_q <= orient_d;
      load_q   <= load_d;
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      flight_q <= flight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  always_comb begin
    push_res.status  = meta_q.status;
    push_res.value   = meta_q.zero ? '0 : rdata;
    push_res.row_end = meta_q.row_end;
    push_res.last    = meta_q.last;
  end

  // output queue, two entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_res;
    end
  end

  assign head          = fifo_q[rptr_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {7'b0, head.row_end, head.value};
  assign m_axis_tuser  = head.status;
  assign m_axis_tlast  = head.last;

endmodule
`default_nettype wire
